// File: src/clc_pkg.sv
// Shared types and constants for the channel levels, colorize and additive blend unit.
package clc_pkg;

    localparam int BYTE_W = 8;
    localparam int NUM_W = 16;
    localparam int QUO_W = 8;
    localparam int DIV_BITS = 2;
    localparam int DIV_STAGES = QUO_W / DIV_BITS;

    localparam logic [BYTE_W-1:0] LUMA_WR = 8'd77;
    localparam logic [BYTE_W-1:0] LUMA_WG = 8'd150;
    localparam logic [BYTE_W-1:0] LUMA_WB = 8'd29;
    localparam logic [BYTE_W-1:0] BYTE_MAX = 8'd255;
    localparam logic [BYTE_W-1:0] TINT_ROUND = 8'd127;

    // floor(x / 255) == (x * RECIP_255) >> RECIP_SHIFT for every 16-bit x.
    localparam logic [16:0] RECIP_255 = 17'h08081;
    localparam int RECIP_SHIFT = 23;
    localparam int RECIP_PROD_W = 33;

    typedef enum logic [2:0] {
        CFG_BLACK = 3'd0,
        CFG_WHITE = 3'd1,
        CFG_TINT_B = 3'd2,
        CFG_TINT_G = 3'd3,
        CFG_TINT_R = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [BYTE_W-1:0] src_blue;
        logic [BYTE_W-1:0] src_green;
        logic [BYTE_W-1:0] src_red;
        logic [BYTE_W-1:0] acc_blue;
        logic [BYTE_W-1:0] acc_green;
        logic [BYTE_W-1:0] acc_red;
    } pix_in_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_blue;
        logic [BYTE_W-1:0] out_green;
        logic [BYTE_W-1:0] out_red;
    } pix_out_t;

    typedef struct packed {
        logic [BYTE_W-1:0] blue;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] red;
    } acc_t;

    // Data that rides along the divider: threshold decisions and the accumulated pixel.
    typedef struct packed {
        logic force_lo;
        logic force_hi;
        acc_t acc;
    } div_side_t;

endpackage

// File: src/clc_in_if.sv
// Input channel: source pixel plus accumulated pixel with valid/ready handshake.
interface clc_in_if import clc_pkg::*; ();
    logic valid;
    logic ready;
    pix_in_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: src/clc_out_if.sv
// Output channel: blended pixel with valid/ready handshake.
interface clc_out_if import clc_pkg::*; ();
    logic valid;
    logic ready;
    pix_out_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: src/channel_levels_colorize_add_unit.sv
// Top level: luminance, levels stretch, tint and saturating additive blend of one pixel.
//
// Usage: each transfer on src carries one source BGR pixel of a fluorescence
// channel and the BGR pixel accumulated so far; dst returns the accumulated
// pixel with the tinted channel intensity added, each byte saturating at 255.
// The five levels and tint registers are written through cfg_we, cfg_index and
// cfg_data; indexes beyond the tint registers are ignored. Write them only while
// no pixel is in flight.
//
// A pixel on src passes the stage 1 and 2 registers, the four divider stages and
// the stage 7, 8 and output registers to reach dst. While dst does not stall, a
// new pixel is taken in every cycle; the rate is one pixel per clock, set by the
// nine-stage pipeline, whose four middle stages form the levels divider.
// The whole pipeline advances together: while dst holds a valid result that is
// not taken, src.ready is low and every stage holds, so nothing is lost or
// repeated; empty stages are never filled by a stall.
// Reset clears all valid bits and loads black 0, white 255 and a white tint.
module channel_levels_colorize_add_unit import clc_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    clc_in_if.sink            src,
    clc_out_if.source         dst,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [BYTE_W-1:0] cfg_data
);

    logic [BYTE_W-1:0] black_reg;
    logic [BYTE_W-1:0] white_reg;
    logic [BYTE_W-1:0] tint_b_reg;
    logic [BYTE_W-1:0] tint_g_reg;
    logic [BYTE_W-1:0] tint_r_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            black_reg <= '0;
            white_reg <= BYTE_MAX;
            tint_b_reg <= BYTE_MAX;
            tint_g_reg <= BYTE_MAX;
            tint_r_reg <= BYTE_MAX;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_BLACK:  black_reg <= cfg_data;
                CFG_WHITE:  white_reg <= cfg_data;
                CFG_TINT_B: tint_b_reg <= cfg_data;
                CFG_TINT_G: tint_g_reg <= cfg_data;
                CFG_TINT_R: tint_r_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    logic adv;
    logic out_vld_reg;

    assign adv = !out_vld_reg || dst.ready;
    assign src.ready = adv;

    // Stage 1: weighted luminance.
    logic              s1_vld_reg;
    logic [BYTE_W-1:0] s1_luma_reg;
    acc_t              s1_acc_reg;
    logic [NUM_W-1:0]  luma_sum;

    assign luma_sum = NUM_W'(src.data.src_red) * NUM_W'(LUMA_WR)
                    + NUM_W'(src.data.src_green) * NUM_W'(LUMA_WG)
                    + NUM_W'(src.data.src_blue) * NUM_W'(LUMA_WB);

    // Stage 2: window decisions and divider numerator.
    logic              s2_vld_reg;
    logic [NUM_W-1:0]  s2_num_reg;
    logic [BYTE_W-1:0] s2_span_reg;
    div_side_t         s2_side_reg;
    logic              force_hi;
    logic              force_lo;
    logic [BYTE_W-1:0] span;
    logic [BYTE_W-1:0] off;
    logic [NUM_W-1:0]  num;

    always_comb
    begin
        force_hi = s1_luma_reg >= white_reg;
        force_lo = !force_hi && ((white_reg <= black_reg) || (s1_luma_reg <= black_reg));
        span = white_reg - black_reg;
        off = s1_luma_reg - black_reg;
        num = {off, 8'd0} - NUM_W'(off) + NUM_W'(span[BYTE_W-1:1]);
    end

    // Stages 3 to 6: divider.
    logic              div_vld;
    logic [QUO_W-1:0]  div_quo;
    logic [NUM_W-1:0]  div_rem;
    div_side_t         div_side;

    clc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_vld   (s2_vld_reg),
        .num      (s2_num_reg),
        .span     (s2_span_reg),
        .side     (s2_side_reg),
        .out_vld  (div_vld),
        .quo      (div_quo),
        .rem      (div_rem),
        .side_out (div_side)
    );

    // Stage 7: intensity times tint, with rounding bias.
    logic              s7_vld_reg;
    logic [NUM_W-1:0]  s7_pb_reg;
    logic [NUM_W-1:0]  s7_pg_reg;
    logic [NUM_W-1:0]  s7_pr_reg;
    acc_t              s7_acc_reg;
    logic [BYTE_W-1:0] inten;

    always_comb
    begin
        if (div_side.force_hi)
        begin
            inten = BYTE_MAX;
        end
        else if (div_side.force_lo)
        begin
            inten = '0;
        end
        else
        begin
            inten = div_quo;
        end
    end

    // Stage 8: divide by 255 through a reciprocal multiply.
    logic              s8_vld_reg;
    logic [BYTE_W-1:0] s8_ab_reg;
    logic [BYTE_W-1:0] s8_ag_reg;
    logic [BYTE_W-1:0] s8_ar_reg;
    acc_t              s8_acc_reg;
    logic [RECIP_PROD_W-1:0] qb_prod;
    logic [RECIP_PROD_W-1:0] qg_prod;
    logic [RECIP_PROD_W-1:0] qr_prod;

    assign qb_prod = RECIP_PROD_W'(s7_pb_reg) * RECIP_PROD_W'(RECIP_255);
    assign qg_prod = RECIP_PROD_W'(s7_pg_reg) * RECIP_PROD_W'(RECIP_255);
    assign qr_prod = RECIP_PROD_W'(s7_pr_reg) * RECIP_PROD_W'(RECIP_255);

    // Stage 9: saturating add into the output register.
    pix_out_t          out_reg;
    logic [BYTE_W:0]   sum_b;
    logic [BYTE_W:0]   sum_g;
    logic [BYTE_W:0]   sum_r;

    assign sum_b = {1'b0, s8_acc_reg.blue} + {1'b0, s8_ab_reg};
    assign sum_g = {1'b0, s8_acc_reg.green} + {1'b0, s8_ag_reg};
    assign sum_r = {1'b0, s8_acc_reg.red} + {1'b0, s8_ar_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s7_vld_reg <= 1'b0;
            s8_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_vld_reg <= src.valid;
            s2_vld_reg <= s1_vld_reg;
            s7_vld_reg <= div_vld;
            s8_vld_reg <= s7_vld_reg;
            out_vld_reg <= s8_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_luma_reg <= luma_sum[NUM_W-1:BYTE_W];
            s1_acc_reg <= '{blue: src.data.acc_blue, green: src.data.acc_green,
                            red: src.data.acc_red};

            s2_num_reg <= num;
            s2_span_reg <= span;
            s2_side_reg <= '{force_lo: force_lo, force_hi: force_hi, acc: s1_acc_reg};

            s7_pb_reg <= NUM_W'(inten) * NUM_W'(tint_b_reg) + NUM_W'(TINT_ROUND);
            s7_pg_reg <= NUM_W'(inten) * NUM_W'(tint_g_reg) + NUM_W'(TINT_ROUND);
            s7_pr_reg <= NUM_W'(inten) * NUM_W'(tint_r_reg) + NUM_W'(TINT_ROUND);
            s7_acc_reg <= div_side.acc;

            s8_ab_reg <= qb_prod[RECIP_SHIFT+BYTE_W-1:RECIP_SHIFT];
            s8_ag_reg <= qg_prod[RECIP_SHIFT+BYTE_W-1:RECIP_SHIFT];
            s8_ar_reg <= qr_prod[RECIP_SHIFT+BYTE_W-1:RECIP_SHIFT];
            s8_acc_reg <= s7_acc_reg;

            out_reg.out_blue <= sum_b[BYTE_W] ? BYTE_MAX : sum_b[BYTE_W-1:0];
            out_reg.out_green <= sum_g[BYTE_W] ? BYTE_MAX : sum_g[BYTE_W-1:0];
            out_reg.out_red <= sum_r[BYTE_W] ? BYTE_MAX : sum_r[BYTE_W-1:0];
        end
    end

    assign dst.valid = out_vld_reg;
    assign dst.data = out_reg;

    // The two threshold decisions never both hold for a pixel in flight.
    assert property (@(posedge clk) disable iff (!rst_n)
        s2_vld_reg |-> !(s2_side_reg.force_lo && s2_side_reg.force_hi))
        else $error("levels window flagged both black and white");

    // A stretched pixel leaves the divider with a remainder below the span.
    assert property (@(posedge clk) disable iff (!rst_n)
        (div_vld && !div_side.force_lo && !div_side.force_hi)
            |-> (div_rem < NUM_W'(white_reg - black_reg)))
        else $error("divider remainder not below the divisor");

    // The blend only adds: each output byte is at least its accumulated byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (adv && s8_vld_reg) |=> (dst.data.out_blue >= $past(s8_acc_reg.blue)
            && dst.data.out_green >= $past(s8_acc_reg.green)
            && dst.data.out_red >= $past(s8_acc_reg.red)))
        else $error("blended byte below accumulated byte");

endmodule

// File: src/clc_div.sv
// Pipelined restoring divider: 16-bit numerator by 8-bit divisor, two quotient bits per stage.
module clc_div import clc_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_vld,
    input  logic [NUM_W-1:0]  num,
    input  logic [BYTE_W-1:0] span,
    input  div_side_t         side,
    output logic              out_vld,
    output logic [QUO_W-1:0]  quo,
    output logic [NUM_W-1:0]  rem,
    output div_side_t         side_out
);

    logic [DIV_STAGES-1:0] vld_reg;
    logic [NUM_W-1:0]      rem_reg  [DIV_STAGES];
    logic [QUO_W-1:0]      quo_reg  [DIV_STAGES];
    logic [BYTE_W-1:0]     span_reg [DIV_STAGES];
    div_side_t             side_reg [DIV_STAGES];

    logic [NUM_W-1:0]      rem_in   [DIV_STAGES];
    logic [QUO_W-1:0]      quo_in   [DIV_STAGES];
    logic [BYTE_W-1:0]     span_in  [DIV_STAGES];
    div_side_t             side_in  [DIV_STAGES];
    logic [NUM_W-1:0]      rem_next [DIV_STAGES];
    logic [QUO_W-1:0]      quo_next [DIV_STAGES];

    always_comb
    begin
        rem_in[0] = num;
        quo_in[0] = '0;
        span_in[0] = span;
        side_in[0] = side;
        for (int s = 1; s < DIV_STAGES; s++)
        begin
            rem_in[s] = rem_reg[s-1];
            quo_in[s] = quo_reg[s-1];
            span_in[s] = span_reg[s-1];
            side_in[s] = side_reg[s-1];
        end
    end

    // For a pixel forced neither high nor low, the numerator is below span * 2**QUO_W, so QUO_W steps suffice.
    always_comb
    begin
        logic [NUM_W-1:0] rem_v;
        logic [NUM_W-1:0] dvs;
        logic [QUO_W-1:0] quo_v;
        int idx;
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            rem_v = rem_in[s];
            quo_v = quo_in[s];
            for (int j = 0; j < DIV_BITS; j++)
            begin
                idx = QUO_W - 1 - s * DIV_BITS - j;
                dvs = NUM_W'(span_in[s]) << idx;
                if (rem_v >= dvs)
                begin
                    rem_v = rem_v - dvs;
                    quo_v[3'(idx)] = 1'b1;
                end
            end
            rem_next[s] = rem_v;
            quo_next[s] = quo_v;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[DIV_STAGES-2:0], in_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < DIV_STAGES; s++)
            begin
                rem_reg[s] <= rem_next[s];
                quo_reg[s] <= quo_next[s];
                span_reg[s] <= span_in[s];
                side_reg[s] <= side_in[s];
            end
        end
    end

    assign out_vld = vld_reg[DIV_STAGES-1];
    assign quo = quo_reg[DIV_STAGES-1];
    assign rem = rem_reg[DIV_STAGES-1];
    assign side_out = side_reg[DIV_STAGES-1];

endmodule
